>>> hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console cell writer
// Screen geometry, field widths, command codes, state and control structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int SCROLL_ROWS   = 5;
  localparam int TAB_STOP      = 4;

  localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SHIFT_CELLS = SCROLL_ROWS * SCREEN_WIDTH;
  localparam int KEEP_CELLS  = CELL_COUNT - SHIFT_CELLS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int X_W    = $clog2(SCREEN_WIDTH);
  localparam int Y_W    = $clog2(SCREEN_HEIGHT);

  // Field widths of the channels
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_ZERO,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic cnt_load;
    logic cnt_inc;
    logic copy_step;
    logic zero_step;
    logic out_load;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic req_clear;
    logic req_scroll;
    logic cnt_at_keep;
    logic cnt_at_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/tcw_req_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if: request channel
// Valid/ready channel carrying one console command per beat.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  cell_col;
  logic [ROW_W-1:0]  cell_row;
  logic              refresh_value;

  modport source (
    output valid, cmd, char_code, cell_col, cell_row, refresh_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, char_code, cell_col, cell_row, refresh_value,
    output ready
  );

endinterface

>>> hw/rtl/tcw_rsp_if.sv
// ----------------------------------------------------------------------------
// tcw_rsp_if: response channel
// Valid/ready channel carrying one result beat per command.
// ----------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              refresh_needed;

  modport source (
    output valid, cell_char, cursor_col, cursor_row, refresh_needed,
    input  ready
  );

  modport sink (
    input  valid, cell_char, cursor_col, cursor_row, refresh_needed,
    output ready
  );

endinterface

>>> hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console controller
// Sequences the reset clearing pass, command acceptance, scroll copy,
// screen clearing and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_INIT: begin
        ctl.zero_step = 1'b1;
        if (sts.cnt_at_last) begin
          state_next = ST_IDLE;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.accept = 1'b1;
          if (sts.req_clear) begin
            ctl.cnt_load = 1'b1;
            state_next   = ST_ZERO;
          end else if (sts.req_scroll) begin
            ctl.cnt_load = 1'b1;
            state_next   = ST_COPY;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_COPY: begin
        // counter runs one past the kept area to flush the last write
        ctl.copy_step = 1'b1;
        if (sts.cnt_at_keep) begin
          state_next = ST_ZERO;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      ST_ZERO: begin
        ctl.zero_step = 1'b1;
        if (sts.cnt_at_last) begin
          state_next = ST_DONE;
        end else begin
          ctl.cnt_inc = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

>>> hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: console datapath
// Cursor and refresh registers, cell RAM port steering, sweep counter and
// the result register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  cell_col,
  input  logic [ROW_W-1:0]  cell_row,
  input  logic              refresh_value,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [CHAR_W-1:0] cell_char,
  output logic [COL_W-1:0]  cursor_col,
  output logic [ROW_W-1:0]  cursor_row,
  output logic              refresh_needed
);

  logic [X_W-1:0]    cur_x;
  logic [Y_W-1:0]    cur_y;
  logic              refresh;
  logic [ADDR_W-1:0] cnt;
  logic              cell_sel;

  logic [X_W:0]      px;
  logic [Y_W:0]      py;
  logic              printable;
  logic              put_active;
  logic              scroll;
  logic              in_range;
  logic [ADDR_W-1:0] cur_idx;
  logic [ADDR_W-1:0] rd_idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // Next cursor position for a put-char
  always_comb begin
    px        = {1'b0, cur_x};
    py        = {1'b0, cur_y};
    printable = 1'b0;
    if (char_code == CODE_NEWLINE) begin
      px = '0;
      py = py + (Y_W+1)'(1);
    end else if (char_code == CODE_TAB) begin
      px = (px | (X_W+1)'(TAB_STOP - 1)) + (X_W+1)'(1);
    end else if (char_code != CODE_NUL) begin
      printable = 1'b1;
      px        = px + (X_W+1)'(1);
    end
    if (px >= (X_W+1)'(SCREEN_WIDTH)) begin
      px = '0;
      py = py + (Y_W+1)'(1);
    end
    scroll = (py >= (Y_W+1)'(SCREEN_HEIGHT));
    if (scroll) begin
      py = py - (Y_W+1)'(SCROLL_ROWS);
    end
  end

  assign put_active = (cmd == CMD_PUT) && (char_code != CODE_NUL);
  assign in_range   = (32'(cell_col) < SCREEN_WIDTH) && (32'(cell_row) < SCREEN_HEIGHT);
  assign cur_idx    = ADDR_W'(ADDR_W'(cur_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_x));
  assign rd_idx     = ADDR_W'(ADDR_W'(cell_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cell_col));

  assign sts.req_clear   = (cmd == CMD_CLEAR);
  assign sts.req_scroll  = put_active && scroll;
  assign sts.cnt_at_keep = (cnt == ADDR_W'(KEEP_CELLS));
  assign sts.cnt_at_last = (cnt == ADDR_W'(CELL_COUNT - 1));
  assign sts.out_free    = !rsp_valid || rsp_ready;

  // Cell RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_idx;
    if (ctl.accept) begin
      ram_we    = (cmd == CMD_PUT) && printable;
      ram_waddr = cur_idx;
      ram_wdata = char_code;
      ram_re    = (cmd == CMD_READ) && in_range;
    end else if (ctl.copy_step) begin
      // read source cell cnt + SHIFT_CELLS, write the registered read data to cell cnt - 1
      ram_re    = !sts.cnt_at_keep;
      ram_raddr = ADDR_W'(cnt + ADDR_W'(SHIFT_CELLS));
      ram_we    = (cnt != '0);
      ram_waddr = cnt - ADDR_W'(1);
      ram_wdata = ram_rdata;
    end else if (ctl.zero_step) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      refresh   <= 1'b1;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        case (cmd)
          CMD_PUT: begin
            if (put_active) begin
              cur_x <= px[X_W-1:0];
              cur_y <= py[Y_W-1:0];
              if (scroll) begin
                refresh <= 1'b1;
              end
            end
          end
          CMD_CLEAR: begin
            cur_x <= '0;
            cur_y <= '0;
          end
          CMD_REFRESH: begin
            refresh <= refresh_value;
          end
          default: begin
          end
        endcase
      end
      if (ctl.cnt_load) begin
        cnt <= '0;
      end else if (ctl.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cell_sel <= (cmd == CMD_READ) && in_range;
    end
    if (ctl.out_load) begin
      cell_char      <= cell_sel ? ram_rdata : '0;
      cursor_col     <= COL_W'(cur_x);
      cursor_row     <= ROW_W'(cur_y);
      refresh_needed <= refresh;
    end
  end

endmodule

>>> hw/rtl/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit: character-cell text console
// Put-char with newline, tab, wrap and five-row scroll; cell read, screen
// clear and refresh flag write. One result beat per request beat.
// ----------------------------------------------------------------------------
//  port  dir   carries
//  req   sink  cmd, char_code, cell_col, cell_row, refresh_value
//  rsp   src   cell_char, cursor_col, cursor_row, refresh_needed
//
// Put-char without a scroll, read and refresh write go through accept, then result load.
// Clear screen zeroes every cell; a scroll copies the kept cells up, then zeroes
// the last SCROLL_ROWS rows; both are bound by the single write port of
// the cell RAM, one cell per cycle.
// After reset a clearing pass over all CELL_COUNT cells runs with req.ready low.
// A held rsp beat does not block the next request from being accepted.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  ctl_t ctl;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcw_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (req.cmd),
    .char_code      (req.char_code),
    .cell_col       (req.cell_col),
    .cell_row       (req.cell_row),
    .refresh_value  (req.refresh_value),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .cell_char      (rsp.cell_char),
    .cursor_col     (rsp.cursor_col),
    .cursor_row     (rsp.cursor_row),
    .refresh_needed (rsp.refresh_needed)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for text_console_cell_writer_unit
// Feeds console commands over the request channel and checks every response
// beat against a console shadow (screen, cursor, refresh flag) that is
// updated as each command is accepted. Directed commands come first, then
// randomized text lines, tab and newline runs, cell reads, refresh writes and
// screen clears. Both sides throttle in phases; the response side stalls once
// for a long stretch to back the unit up.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int N_RANDOM    = 1100;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYC   = 2100;   // longer than a clear or a scroll
  localparam int HOLD_CYC    = 300;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
    logic              refresh_value;
  } con_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              refresh_needed;
  } con_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();

  text_console_cell_writer_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // console shadow
  logic [CHAR_W-1:0] scr_mem [CELL_COUNT];
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic              refresh_flag;

  con_cmd_t  cmd_q  [$];
  con_view_t view_q [$];
  con_cmd_t  drv_cmd;
  con_view_t got_view, want_view;

  int n_total;
  int n_cmd_acc;
  int n_errs;
  int stall_cnt;
  int hold_left;
  bit hold_done;

  function automatic void console_reset();
    foreach (scr_mem[i]) scr_mem[i] = '0;
    cur_x        = 0;
    cur_y        = 0;
    refresh_flag = 1'b1;
  endfunction

  function automatic void console_putc(logic [CHAR_W-1:0] c);
    int unsigned idx;
    if (c == CODE_NUL) return;    // terminator, never stored
    if (c == CODE_NEWLINE) begin
      cur_x = 0;
      cur_y++;
    end else if (c == CODE_TAB) begin
      cur_x += TAB_STOP - (cur_x % TAB_STOP);
    end else begin
      idx = cur_y * SCREEN_WIDTH + cur_x;
      if (idx < CELL_COUNT) scr_mem[idx] = c;
      cur_x++;
    end
    if (cur_x >= SCREEN_WIDTH) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= SCREEN_HEIGHT) begin
      for (int i = 0; i < KEEP_CELLS; i++) scr_mem[i] = scr_mem[i + SHIFT_CELLS];
      for (int i = KEEP_CELLS; i < CELL_COUNT; i++) scr_mem[i] = '0;
      cur_y       -= SCROLL_ROWS;
      refresh_flag = 1'b1;
    end
  endfunction

  function automatic con_view_t console_apply(con_cmd_t c);
    con_view_t v;
    v.cell_char = '0;
    case (c.cmd)
      CMD_PUT: console_putc(c.char_code);
      CMD_READ: begin
        if (c.cell_col < SCREEN_WIDTH && c.cell_row < SCREEN_HEIGHT)
          v.cell_char = scr_mem[c.cell_row * SCREEN_WIDTH + c.cell_col];
      end
      CMD_CLEAR: begin
        foreach (scr_mem[i]) scr_mem[i] = '0;
        cur_x = 0;
        cur_y = 0;
      end
      CMD_REFRESH: refresh_flag = c.refresh_value;
      default: ;
    endcase
    v.cursor_col     = COL_W'(cur_x);
    v.cursor_row     = ROW_W'(cur_y);
    v.refresh_needed = refresh_flag;
    return v;
  endfunction

  // unused fields are randomized too
  function automatic con_cmd_t make_item(cmd_t op);
    con_cmd_t c;
    c.cmd           = op;
    c.char_code     = CHAR_W'($urandom);
    c.cell_col      = COL_W'($urandom);
    c.cell_row      = ROW_W'($urandom);
    c.refresh_value = 1'($urandom);
    return c;
  endfunction

  function automatic void add_put(logic [CHAR_W-1:0] ch);
    con_cmd_t c;
    c           = make_item(CMD_PUT);
    c.char_code = ch;
    cmd_q.push_back(c);
  endfunction

  function automatic void add_read(int col, int row);
    con_cmd_t c;
    c          = make_item(CMD_READ);
    c.cell_col = COL_W'(col);
    c.cell_row = ROW_W'(row);
    cmd_q.push_back(c);
  endfunction

  function automatic void add_op(cmd_t op, logic rv);
    con_cmd_t c;
    c               = make_item(op);
    c.refresh_value = rv;
    cmd_q.push_back(c);
  endfunction

  // throttle percentage per phase: sender 33/81/0, receiver 81/33/0
  function automatic int idle_pct(bit rx_side);
    if (n_cmd_acc < n_total / 3) return rx_side ? 81 : 33;
    if (n_cmd_acc < 2 * n_total / 3) return rx_side ? 33 : 81;
    return 0;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        view_q.push_back(console_apply(drv_cmd));
        n_cmd_acc++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          drv_cmd                = cmd_q.pop_front();
          req_if.valid          <= 1'b1;
          req_if.cmd            <= drv_cmd.cmd;
          req_if.char_code      <= drv_cmd.char_code;
          req_if.cell_col       <= drv_cmd.cell_col;
          req_if.cell_row       <= drv_cmd.cell_row;
          req_if.refresh_value  <= drv_cmd.refresh_value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with one long hold-off in the unthrottled phase
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_cmd_acc >= 2 * n_total / 3 + 20) begin
      rsp_if.ready <= 1'b0;
      hold_done     = 1'b1;
      hold_left     = HOLD_CYC - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got_view = '{rsp_if.cell_char, rsp_if.cursor_col, rsp_if.cursor_row,
                   rsp_if.refresh_needed};
      if (view_q.size() == 0) begin
        if (n_errs < 10)
          $display("%0t: unexpected beat char %h col %0d row %0d refresh %b", $time,
                   got_view.cell_char, got_view.cursor_col, got_view.cursor_row,
                   got_view.refresh_needed);
        n_errs++;
      end else begin
        want_view = view_q.pop_front();
        if (got_view.cell_char !== want_view.cell_char ||
            got_view.cursor_col !== want_view.cursor_col ||
            got_view.cursor_row !== want_view.cursor_row ||
            got_view.refresh_needed !== want_view.refresh_needed) begin
          if (n_errs < 10)
            $display("%0t: mismatch exp char %h col %0d row %0d refresh %b, got char %h col %0d row %0d refresh %b",
                     $time, want_view.cell_char, want_view.cursor_col,
                     want_view.cursor_row, want_view.refresh_needed,
                     got_view.cell_char, got_view.cursor_col, got_view.cursor_row,
                     got_view.refresh_needed);
          n_errs++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("text_console_cell_writer_unit test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int r, len, n_rand;
    req_if.valid         = 1'b0;
    req_if.cmd           = CMD_PUT;
    req_if.char_code     = '0;
    req_if.cell_col      = '0;
    req_if.cell_row      = '0;
    req_if.refresh_value = 1'b0;
    rsp_if.ready         = 1'b0;
    n_cmd_acc            = 0;
    n_errs               = 0;
    stall_cnt            = 0;
    console_reset();

    // directed: char extremes, NUL, tab, newline, reads in and out of range,
    // refresh writes, clear keeping the flag
    add_put(8'h48);
    add_put(8'hFF);
    add_put(CODE_NUL);
    add_put(CODE_TAB);
    add_put(8'h01);
    add_put(CODE_NEWLINE);
    add_read(0, 0);
    add_read(1, 0);
    add_read(4, 0);
    add_read(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    add_read(SCREEN_WIDTH, 0);
    add_read(0, SCREEN_HEIGHT);
    add_read(127, 31);
    add_op(CMD_REFRESH, 1'b0);
    add_op(CMD_REFRESH, 1'b1);
    add_op(CMD_REFRESH, 1'b0);
    add_put(8'h80);
    add_put(CODE_TAB);
    add_op(CMD_CLEAR, 1'b1);
    add_read(0, 0);
    add_read(1, 0);

    // random: mostly text lines, with runs that force wraps and scrolls
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      r = $urandom_range(99);
      if (r < 45) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (r < 72)      add_put(CHAR_W'($urandom_range(32, 126)));
          else if (r < 80) add_put(CODE_TAB);
          else if (r < 84) add_put(CODE_NUL);
          else if (r < 88) add_put(CODE_NEWLINE);
          else             add_put(CHAR_W'($urandom));
        end
        if ($urandom_range(9) < 7) add_put(CODE_NEWLINE);
        n_rand += len + 1;
      end else if (r < 60) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 80)
            add_read($urandom_range(SCREEN_WIDTH - 1), $urandom_range(SCREEN_HEIGHT - 1));
          else
            add_read($urandom_range(127), $urandom_range(31));
        end
        n_rand += len;
      end else if (r < 68) begin
        add_op(CMD_REFRESH, 1'($urandom));
        n_rand++;
      end else if (r < 76) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) add_put(CODE_NEWLINE);
        n_rand += len;
      end else if (r < 84) begin
        // enough tabs to cross the right edge from column 0
        len = $urandom_range(1, 25);
        for (int i = 0; i < len; i++) add_put(CODE_TAB);
        n_rand += len;
      end else if (r < 87) begin
        add_op(CMD_CLEAR, 1'($urandom));
        n_rand++;
      end else begin
        cmd_q.push_back(make_item(cmd_t'($urandom_range(3))));
        n_rand++;
      end
    end
    n_total = cmd_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_cmd_acc < n_total) @(posedge clk);
    while (view_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errs == 0) begin
      $display("text_console_cell_writer_unit test passed");
    end else begin
      $display("text_console_cell_writer_unit test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_req_if.sv
hw/rtl/tcw_rsp_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_cell_writer_unit.sv
tb/tb_top.sv
